// File: hw/rtl/qls_pkg.sv
// Shared constants, types and helpers for the quadrilinear table sampler.
package qls_pkg;

    // Grid size along each axis
    localparam int ROUGH_STEPS    = 64;
    localparam int VIEW_STEPS     = 64;
    localparam int STRENGTH_STEPS = 8;
    localparam int AZIMUTH_STEPS  = 8;

    localparam int LUT_DEPTH = ROUGH_STEPS * VIEW_STEPS * STRENGTH_STEPS * AZIMUTH_STEPS;
    localparam int ADDR_W    = $clog2(LUT_DEPTH);

    // Index widths per axis
    localparam int RW    = $clog2(ROUGH_STEPS);
    localparam int VW    = $clog2(VIEW_STEPS);
    localparam int SW    = $clog2(STRENGTH_STEPS);
    localparam int AW    = $clog2(AZIMUTH_STEPS);
    localparam int IDX_W = (RW > VW ? RW : VW) > (SW > AW ? SW : AW) ?
                           (RW > VW ? RW : VW) : (SW > AW ? SW : AW);

    // Coordinate widths: grid index above 16 fraction bits
    localparam int RCW = 16 + RW;
    localparam int VCW = 16 + VW;
    localparam int SCW = 17 + SW;
    localparam int ACW = 17 + AW;
    localparam int CRD_W = 17 + IDX_W;

    // Fixed-point constants in Q.16 / Q0.24
    localparam int ONE_Q16         = 65536;
    localparam int ROUGH_BIAS      = 2621;
    localparam int ROUGH_SPAN      = 62915;
    localparam int VIEW_FLOOR      = 7;
    localparam int VIEW_SPAN       = 64881;
    localparam int TWO_OVER_PI_Q24 = 10680707;

    // Square-root steps
    localparam int SQ_STEP = 17;

    // Scale by (steps-1)*2^16/span as a multiply by the rounded-up reciprocal
    // in units of 2^-32; exact for every numerator below 2^16
    localparam int     RECIP_SHIFT = 32;
    localparam longint ROUGH_RECIP =
        ((longint'(ROUGH_STEPS - 1) << (16 + RECIP_SHIFT)) + ROUGH_SPAN - 1) / ROUGH_SPAN;
    localparam longint VIEW_RECIP  =
        ((longint'(VIEW_STEPS - 1) << (16 + RECIP_SHIFT)) + VIEW_SPAN - 1) / VIEW_SPAN;

    // Shared multiplier port widths
    localparam int MUL_A_W = 17;
    localparam int MUL_B_W = 24;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Accumulator in units of 2^-40
    localparam int ACC_W = 60;

    typedef struct packed {
        logic [IDX_W-1:0] lo;
        logic [IDX_W-1:0] hi;
        logic [15:0]      frac;
    } axis_t;

    typedef struct packed {
        logic           done;
        logic [RCW-1:0] rough;
        logic [VCW-1:0] view;
    } coord_res_t;

    // Clamp a coordinate to the last grid point and split it
    function automatic axis_t split_axis(input logic [CRD_W-1:0] coord, input int steps);
        logic [CRD_W-1:0] limit;
        logic [CRD_W-1:0] c;
        axis_t            ax;
        limit   = CRD_W'(steps - 1) << 16;
        c       = (coord > limit) ? limit : coord;
        ax.lo   = c[16 +: IDX_W];
        ax.frac = c[15:0];
        ax.hi   = (ax.lo < IDX_W'(steps - 1)) ? ax.lo + 1'b1 : ax.lo;
        return ax;
    endfunction

endpackage

// File: hw/rtl/qls_mul.sv
// Shared unsigned multiplier with a registered product.
module qls_mul import qls_pkg::*; (
    input  logic               aclk,
    input  logic [MUL_A_W-1:0] mul_a,
    input  logic [MUL_B_W-1:0] mul_b,
    output logic [MUL_P_W-1:0] mul_p
);

    logic [MUL_P_W-1:0] prod_reg;

    // Register every product
    always_ff @(posedge aclk) begin
        prod_reg <= MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
    end

    assign mul_p = prod_reg;

endmodule

// File: hw/rtl/qls_lut.sv
// Table memory: one write port, one registered read port.
module qls_lut import qls_pkg::*; (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [31:0]       wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [31:0]       rd_data
);

    logic [31:0] mem [LUT_DEPTH];
    logic [31:0] rd_data_reg;

    // Write one word
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read one word, hold it until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/qls_coord.sv
// Roughness and view coordinates: square root on one subtractor, then reciprocal scaling.
module qls_coord import qls_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [15:0] rough_n,
    input  logic [16:0] view_v,
    output coord_res_t  res
);

    localparam logic [1:0] CS_IDLE  = 2'd0;
    localparam logic [1:0] CS_SQRT  = 2'd1;
    localparam logic [1:0] CS_SCALE = 2'd2;
    localparam int CNT_W = $clog2(SQ_STEP);

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [33:0]      x_reg, x_next;
    logic [16:0]      root_reg, root_next;
    logic [19:0]      rem_reg, rem_next;
    logic [63:0]      acc_reg, acc_next;
    logic [15:0]      n_reg, n_next;
    logic [RCW-1:0]   rough_reg, rough_next;
    logic [VCW-1:0]   view_reg, view_next;
    logic             done_reg, done_next;

    logic [19:0] sub_a, sub_b;
    logic [20:0] diff;
    logic        ge;
    logic [16:0] one_minus;
    logic [16:0] sc_a;
    logic [63:0] recip;
    logic [23:0] sc_b;
    logic [40:0] prod;
    logic [63:0] sum;

    // Shared compare-and-subtract unit for the square root
    always_comb begin
        sub_a = {rem_reg[17:0], x_reg[33:32]};
        sub_b = {1'b0, root_reg, 2'b01};
        diff  = {1'b0, sub_a} - {1'b0, sub_b};
        ge    = !diff[20];
    end

    assign one_minus = 17'(ONE_Q16) - root_reg;

    // Reciprocal scaling: low then high part of the reciprocal, roughness then view
    always_comb begin
        sc_a  = cnt_reg[1] ? one_minus : {1'b0, n_reg};
        recip = cnt_reg[1] ? 64'(VIEW_RECIP) : 64'(ROUGH_RECIP);
        sc_b  = cnt_reg[0] ? recip[47:24] : recip[23:0];
        prod  = 41'(sc_a) * 41'(sc_b);
        sum   = acc_reg + (64'(prod) << 24);
    end

    // Sequence square root, then roughness and view scaling
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        x_next     = x_reg;
        root_next  = root_reg;
        rem_next   = rem_reg;
        acc_next   = acc_reg;
        n_next     = n_reg;
        rough_next = rough_reg;
        view_next  = view_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            CS_IDLE: begin
                if (start) begin
                    x_next     = {1'b0, view_v, 16'b0};
                    root_next  = '0;
                    rem_next   = '0;
                    n_next     = rough_n;
                    cnt_next   = CNT_W'(SQ_STEP - 1);
                    state_next = CS_SQRT;
                end
            end
            CS_SQRT: begin
                x_next    = {x_reg[31:0], 2'b00};
                root_next = {root_reg[15:0], ge};
                rem_next  = ge ? diff[19:0] : sub_a;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    cnt_next   = '0;
                    state_next = CS_SCALE;
                end
            end
            CS_SCALE: begin
                cnt_next = cnt_reg + 1'b1;
                if (!cnt_reg[0]) begin
                    acc_next = 64'(prod);
                end else if (!cnt_reg[1]) begin
                    rough_next = sum[RECIP_SHIFT +: RCW];
                end else begin
                    view_next  = sum[RECIP_SHIFT +: VCW];
                    done_next  = 1'b1;
                    state_next = CS_IDLE;
                end
            end
            default: state_next = CS_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        cnt_reg   <= cnt_next;
        x_reg     <= x_next;
        root_reg  <= root_next;
        rem_reg   <= rem_next;
        acc_reg   <= acc_next;
        n_reg     <= n_next;
        rough_reg <= rough_next;
        view_reg  <= view_next;
    end

    assign res.done  = done_reg;
    assign res.rough = rough_reg;
    assign res.view  = view_reg;

endmodule

// File: hw/rtl/quadrilinear_lut_sampler.sv
// Quadrilinear sampler over a four-axis table of two half-float channels.
//
//  channel | ports                                        | direction
//  --------+----------------------------------------------+----------
//  input   | s_valid s_ready s_mode s_load_* s_<coords>    | in
//  result  | m_valid m_ready m_result_first m_result_second| out
//
// A sample closes the input while it runs: it scales azimuth, waits for the
// 17-step square root and four reciprocal multiply steps of the coordinate
// unit, then for each of 16 corners forms the weight and both channel terms
// on the shared multiplier, then rounds. Reset clears control only; table
// entries hold garbage until written. A result held by m_ready low stalls
// the rounding of the next one.
module quadrilinear_lut_sampler import qls_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_mode,
    input  logic [17:0]        s_load_address,
    input  logic [15:0]        s_load_first,
    input  logic [15:0]        s_load_second,
    input  logic signed [17:0] s_view_cosine,
    input  logic signed [17:0] s_roughness,
    input  logic signed [17:0] s_strength,
    input  logic signed [17:0] s_azimuth,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_result_first,
    output logic signed [31:0] m_result_second
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_AZ    = 4'd1;
    localparam logic [3:0] ST_WAIT  = 4'd2;
    localparam logic [3:0] ST_C_W01 = 4'd3;
    localparam logic [3:0] ST_C_W23 = 4'd4;
    localparam logic [3:0] ST_C_WT  = 4'd5;
    localparam logic [3:0] ST_C_M0  = 4'd6;
    localparam logic [3:0] ST_C_M1  = 4'd7;
    localparam logic [3:0] ST_C_A1  = 4'd8;
    localparam logic [3:0] ST_FIN   = 4'd9;

    typedef struct packed {
        logic nan;
        logic pinf;
        logic ninf;
    } spec_t;

    logic [3:0]              state_reg, state_next;
    axis_t                   ax_reg [4];
    axis_t                   ax_next [4];
    logic [SCW-1:0]          cs_reg, cs_next;
    logic [ACW-1:0]          ca_reg, ca_next;
    logic [3:0]              corner_reg, corner_next;
    logic [16:0]             w01_reg, w01_next;
    logic [16:0]             weight_reg, weight_next;
    logic signed [ACC_W-1:0] acc0_reg, acc0_next, acc1_reg, acc1_next;
    spec_t                   sp0_reg, sp0_next, sp1_reg, sp1_next;
    logic                    m_valid_reg, m_valid_next;
    logic [31:0]             res0_reg, res0_next, res1_reg, res1_next;

    logic               accept, start;
    logic [15:0]        rough_n;
    logic [16:0]        view_v;
    logic [16:0]        str_c;
    logic signed [18:0] rn;
    coord_res_t         cres;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] mul_p;
    logic [16:0]        w [4];
    logic [IDX_W-1:0]   idx [4];
    logic [ADDR_W-1:0]  rd_addr;
    logic [31:0]        rd_data;
    logic [16:0]        t_az;

    // Half decode: mantissa, shift, sign, special
    logic [10:0] mant0, mant1;
    logic [4:0]  sh0, sh1;
    logic [4:0]  e0, e1;
    logic signed [ACC_W-1:0] term;
    logic [15:0] hcur;
    logic [4:0]  shcur;

    assign accept = s_valid && s_ready;
    assign start  = accept && s_mode;
    assign s_ready = (state_reg == ST_IDLE);

    // Clamp raw inputs for the coordinate unit and the strength axis
    always_comb begin
        rn = 19'(s_roughness) - 19'(ROUGH_BIAS);
        if (rn < 0) begin
            rough_n = '0;
        end else if (rn > 19'(ROUGH_SPAN)) begin
            rough_n = 16'(ROUGH_SPAN);
        end else begin
            rough_n = rn[15:0];
        end
        if (s_view_cosine < 18'(VIEW_FLOOR)) begin
            view_v = 17'(VIEW_FLOOR);
        end else if (s_view_cosine > 18'(ONE_Q16)) begin
            view_v = 17'(ONE_Q16);
        end else begin
            view_v = s_view_cosine[16:0];
        end
        if (s_strength < 0) begin
            str_c = '0;
        end else if (s_strength > 18'(ONE_Q16)) begin
            str_c = 17'(ONE_Q16);
        end else begin
            str_c = s_strength[16:0];
        end
    end

    qls_coord u_coord (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .rough_n (rough_n),
        .view_v  (view_v),
        .res     (cres)
    );

    // Corner indices and axis weights
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            idx[k] = corner_reg[k] ? ax_reg[k].hi : ax_reg[k].lo;
            w[k]   = corner_reg[k] ? {1'b0, ax_reg[k].frac}
                                   : 17'(ONE_Q16) - {1'b0, ax_reg[k].frac};
        end
        rd_addr = ((ADDR_W'(idx[2]) * ADDR_W'(AZIMUTH_STEPS) + ADDR_W'(idx[3]))
                   * ADDR_W'(VIEW_STEPS) + ADDR_W'(idx[1])) * ADDR_W'(ROUGH_STEPS)
                  + ADDR_W'(idx[0]);
    end

    qls_lut u_lut (
        .aclk    (aclk),
        .wr_en   (accept && !s_mode && (32'(s_load_address) < 32'(LUT_DEPTH))),
        .wr_addr (ADDR_W'(s_load_address)),
        .wr_data ({s_load_second, s_load_first}),
        .rd_en   (state_reg == ST_C_W01),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Decode both half channels of the corner word
    always_comb begin
        e0    = rd_data[14:10];
        e1    = rd_data[30:26];
        mant0 = {(e0 != '0), rd_data[9:0]};
        mant1 = {(e1 != '0), rd_data[25:16]};
        sh0   = (e0 != '0) ? e0 - 1'b1 : '0;
        sh1   = (e1 != '0) ? e1 - 1'b1 : '0;
        hcur  = (state_reg == ST_C_M1) ? rd_data[15:0] : rd_data[31:16];
        shcur = (state_reg == ST_C_M1) ? sh0 : sh1;
        term  = ACC_W'(mul_p[27:0]) << shcur;
        if (hcur[15]) begin
            term = -term;
        end
    end

    // Multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_IDLE:  begin
                mul_a = (s_azimuth > 0) ? s_azimuth[16:0] : '0;
                mul_b = 24'(TWO_OVER_PI_Q24);
            end
            ST_C_W01: begin
                mul_a = w[0];
                mul_b = 24'(w[1]);
            end
            ST_C_W23: begin
                mul_a = w[2];
                mul_b = 24'(w[3]);
            end
            ST_C_WT:  begin
                mul_a = w01_reg;
                mul_b = 24'(mul_p[32:16]);
            end
            ST_C_M0:  begin
                mul_a = 17'(mant0);
                mul_b = 24'(mul_p[32:16]);
            end
            ST_C_M1:  begin
                mul_a = 17'(mant1);
                mul_b = 24'(weight_reg);
            end
            ST_AZ, ST_WAIT, ST_C_A1, ST_FIN: begin
                mul_a = '0;
                mul_b = '0;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    qls_mul u_mul (
        .aclk  (aclk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .mul_p (mul_p)
    );

    assign t_az = (mul_p[MUL_P_W-1:24] > (MUL_P_W-24)'(ONE_Q16)) ?
                  17'(ONE_Q16) : mul_p[40:24];

    // Round to Q16.16 and saturate, or flag a special value
    function automatic logic [31:0] finish_ch(input logic signed [ACC_W-1:0] acc,
                                              input spec_t sp);
        logic signed [ACC_W-1:0] r;
        logic signed [ACC_W-1:0] q;
        logic [31:0]             res;
        r = acc + (ACC_W'(1) << 23);
        q = r >>> 24;
        if (sp.nan || sp.pinf) begin
            res = 32'h7FFF_FFFF;
        end else if (sp.ninf) begin
            res = 32'h8000_0000;
        end else if (q > $signed(ACC_W'(32'h7FFF_FFFF))) begin
            res = 32'h7FFF_FFFF;
        end else if (q < -(ACC_W'(1) << 31)) begin
            res = 32'h8000_0000;
        end else begin
            res = q[31:0];
        end
        return res;
    endfunction

    // Sample sequencer
    always_comb begin
        state_next   = state_reg;
        ax_next      = ax_reg;
        cs_next      = cs_reg;
        ca_next      = ca_reg;
        corner_next  = corner_reg;
        w01_next     = w01_reg;
        weight_next  = weight_reg;
        acc0_next    = acc0_reg;
        acc1_next    = acc1_reg;
        sp0_next     = sp0_reg;
        sp1_next     = sp1_reg;
        res0_next    = res0_reg;
        res1_next    = res1_reg;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    cs_next    = SCW'(str_c) * SCW'(STRENGTH_STEPS - 1);
                    state_next = ST_AZ;
                end
            end
            ST_AZ: begin
                ca_next    = ACW'(t_az) * ACW'(AZIMUTH_STEPS - 1);
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (cres.done) begin
                    ax_next[0]  = split_axis(CRD_W'(cres.rough), ROUGH_STEPS);
                    ax_next[1]  = split_axis(CRD_W'(cres.view), VIEW_STEPS);
                    ax_next[2]  = split_axis(CRD_W'(cs_reg), STRENGTH_STEPS);
                    ax_next[3]  = split_axis(CRD_W'(ca_reg), AZIMUTH_STEPS);
                    corner_next = '0;
                    acc0_next   = '0;
                    acc1_next   = '0;
                    sp0_next    = '0;
                    sp1_next    = '0;
                    state_next  = ST_C_W01;
                end
            end
            ST_C_W01: state_next = ST_C_W23;
            ST_C_W23: begin
                w01_next   = mul_p[32:16];
                state_next = ST_C_WT;
            end
            ST_C_WT:  state_next = ST_C_M0;
            ST_C_M0: begin
                weight_next = mul_p[32:16];
                state_next  = ST_C_M1;
            end
            ST_C_M1: begin
                if (e0 == 5'd31) begin
                    sp0_next.nan  = sp0_reg.nan  || (rd_data[9:0] != '0);
                    sp0_next.pinf = sp0_reg.pinf || (rd_data[9:0] == '0 && !rd_data[15]);
                    sp0_next.ninf = sp0_reg.ninf || (rd_data[9:0] == '0 && rd_data[15]);
                end else begin
                    acc0_next = acc0_reg + term;
                end
                state_next = ST_C_A1;
            end
            ST_C_A1: begin
                if (e1 == 5'd31) begin
                    sp1_next.nan  = sp1_reg.nan  || (rd_data[25:16] != '0);
                    sp1_next.pinf = sp1_reg.pinf || (rd_data[25:16] == '0 && !rd_data[31]);
                    sp1_next.ninf = sp1_reg.ninf || (rd_data[25:16] == '0 && rd_data[31]);
                end else begin
                    acc1_next = acc1_reg + term;
                end
                corner_next = corner_reg + 1'b1;
                state_next  = (corner_reg == 4'hF) ? ST_FIN : ST_C_W01;
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    res0_next    = finish_ch(acc0_reg, sp0_reg);
                    res1_next    = finish_ch(acc1_reg, sp1_reg);
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        ax_reg     <= ax_next;
        cs_reg     <= cs_next;
        ca_reg     <= ca_next;
        corner_reg <= corner_next;
        w01_reg    <= w01_next;
        weight_reg <= weight_next;
        acc0_reg   <= acc0_next;
        acc1_reg   <= acc1_next;
        sp0_reg    <= sp0_next;
        sp1_reg    <= sp1_next;
        res0_reg   <= res0_next;
        res1_reg   <= res1_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_result_first  = res0_reg;
    assign m_result_second = res1_reg;

endmodule

// File: hw/rtl/qls_checker.sv
// Port-level checks for the sampler, bound to the top level.
module qls_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_mode,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_result_first,
    input logic [31:0] m_result_second
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_first) && $stable(m_result_second))
        else $error("stalled result changed");

    // Reset empties the output
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A table write gives no item
    a_write_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_mode |=> !$rose(m_valid))
        else $error("result after table write");

    // A sample closes the input after acceptance; only the start of its run is checked
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_mode |=> !s_ready ##1 !s_ready)
        else $error("input open during sample");

endmodule

bind quadrilinear_lut_sampler qls_checker u_qls_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .s_mode          (s_mode),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_result_first  (m_result_first),
    .m_result_second (m_result_second)
);
